>>> rtl/core/pci_pkg.sv
// Shared types and constants for the permutation check and inversion counter.
package pci_pkg;

  localparam int PermMaxDefault = 64;
  localparam int ValW           = 8;
  localparam int InvW           = 11;
  localparam int GrpW           = 7;
  localparam int CntOutW        = 7;
  localparam logic [InvW-1:0] InvSat = '1;

  typedef struct packed {
    logic [ValW-1:0] entry_value;
    logic            last_entry;
  } in_word_t;

  typedef struct packed {
    logic               is_permutation;
    logic [InvW-1:0]    inversion_count;
    logic [GrpW-1:0]    group_size;
    logic [CntOutW-1:0] entry_count;
  } out_word_t;

endpackage

>>> rtl/core/pci_step.sv
// Next-state logic for one permutation entry: bitmap popcount, checks, running totals.
module pci_step #(
  parameter int PERM_MAX = pci_pkg::PermMaxDefault,
  localparam int PosW = $clog2(PERM_MAX + 1),
  localparam int IdxW = $clog2(PERM_MAX),
  localparam int CmpW = (PosW > pci_pkg::ValW) ? PosW : pci_pkg::ValW
) (
  input  logic [pci_pkg::ValW-1:0] entry_value_i,
  input  logic [PERM_MAX-1:0]      seen_i,
  input  logic [PosW-1:0]          pos_i,
  input  logic [pci_pkg::InvW-1:0] inv_i,
  input  logic [PosW-1:0]          moved_i,
  input  logic [pci_pkg::ValW-1:0] largest_i,
  input  logic                     bad_i,
  output logic [PERM_MAX-1:0]      seen_o,
  output logic [PosW-1:0]          pos_o,
  output logic [pci_pkg::InvW-1:0] inv_o,
  output logic [PosW-1:0]          moved_o,
  output logic [pci_pkg::ValW-1:0] largest_o,
  output logic                     bad_o,
  output logic                     perm_ok_o
);

  localparam int SumW = pci_pkg::InvW + 1;

  logic [CmpW-1:0] val_ext;
  logic [CmpW-1:0] val_m1;
  logic [IdxW-1:0] idx;
  logic [PosW-1:0] pos_inc;
  logic [PosW-1:0] larger_cnt;
  logic [SumW-1:0] inv_sum;
  logic            full;
  logic            out_of_range;

  assign val_ext      = CmpW'(entry_value_i);
  assign val_m1       = val_ext - CmpW'(1);
  assign idx          = val_m1[IdxW-1:0];
  assign full         = (pos_i == PosW'(PERM_MAX));
  assign pos_inc      = pos_i + PosW'(1);
  assign out_of_range = (entry_value_i == '0) || (val_ext > CmpW'(PERM_MAX));

  // earlier values strictly above this one: bit i holds value i+1
  always_comb begin
    larger_cnt = '0;
    for (int i = 0; i < PERM_MAX; i++) begin
      if (seen_i[i] && (CmpW'(i) >= val_ext)) begin
        larger_cnt = larger_cnt + PosW'(1);
      end
    end
  end

  assign inv_sum = SumW'(inv_i) + SumW'(larger_cnt);

  always_comb begin
    seen_o    = seen_i;
    pos_o     = pos_i;
    inv_o     = inv_i;
    moved_o   = moved_i;
    largest_o = largest_i;
    bad_o     = bad_i;
    if (full) begin
      bad_o = 1'b1;
    end else begin
      pos_o = pos_inc;
      if (val_ext != CmpW'(pos_inc)) begin
        moved_o = pos_inc;
      end
      if (entry_value_i > largest_i) begin
        largest_o = entry_value_i;
      end
      if (out_of_range) begin
        bad_o = 1'b1;
      end else begin
        inv_o = (inv_sum > SumW'(pci_pkg::InvSat)) ? pci_pkg::InvSat
                                                   : inv_sum[pci_pkg::InvW-1:0];
        if (seen_i[idx]) begin
          bad_o = 1'b1;
        end else begin
          seen_o[idx] = 1'b1;
        end
      end
    end
  end

  assign perm_ok_o = !bad_o && (CmpW'(largest_o) <= CmpW'(pos_o));

endmodule

>>> rtl/core/permutation_check_and_inversions.sv
// Top level: permutation checker and inversion counter, one entry per word.
// Entries stream in one word per cycle with no gaps needed; each word is
// registered, then folded into the seen-value bitmap and running totals by
// combinational logic (one masked popcount over PERM_MAX bitmap bits sets the path).
// The word marked last_entry yields one result word, registered as it leaves the
// input register; the state returns to empty so the next permutation can follow
// at once. Output stall holds back only a last entry; other entries keep flowing.
module permutation_check_and_inversions #(
  parameter int PERM_MAX = pci_pkg::PermMaxDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  pci_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output pci_pkg::out_word_t out_word_o
);

  localparam int PosW = $clog2(PERM_MAX + 1);

  logic               s0_valid_q, s0_valid_d;
  pci_pkg::in_word_t  s0_word_q;
  logic               out_valid_q, out_valid_d;
  pci_pkg::out_word_t out_word_q;

  logic [PERM_MAX-1:0]      seen_q, seen_d, seen_nx;
  logic [PosW-1:0]          pos_q, pos_d, pos_nx;
  logic [pci_pkg::InvW-1:0] inv_q, inv_d, inv_nx;
  logic [PosW-1:0]          moved_q, moved_d, moved_nx;
  logic [pci_pkg::ValW-1:0] largest_q, largest_d, largest_nx;
  logic                     bad_q, bad_d, bad_nx;
  logic                     perm_ok;
  logic                     fire;
  logic                     in_acc;

  pci_step #(.PERM_MAX(PERM_MAX)) u_step (
    .entry_value_i (s0_word_q.entry_value),
    .seen_i        (seen_q),
    .pos_i         (pos_q),
    .inv_i         (inv_q),
    .moved_i       (moved_q),
    .largest_i     (largest_q),
    .bad_i         (bad_q),
    .seen_o        (seen_nx),
    .pos_o         (pos_nx),
    .inv_o         (inv_nx),
    .moved_o       (moved_nx),
    .largest_o     (largest_nx),
    .bad_o         (bad_nx),
    .perm_ok_o     (perm_ok)
  );

  assign fire       = s0_valid_q && (!s0_word_q.last_entry || !out_valid_q || !out_stall_i);
  assign in_stall_o = s0_valid_q && !fire;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign s0_valid_d = in_acc ? 1'b1 : (fire ? 1'b0 : s0_valid_q);

  always_comb begin
    out_valid_d = out_valid_q;
    if (fire && s0_word_q.last_entry) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_comb begin
    seen_d    = seen_q;
    pos_d     = pos_q;
    inv_d     = inv_q;
    moved_d   = moved_q;
    largest_d = largest_q;
    bad_d     = bad_q;
    if (fire) begin
      if (s0_word_q.last_entry) begin
        seen_d    = '0;
        pos_d     = '0;
        inv_d     = '0;
        moved_d   = '0;
        largest_d = '0;
        bad_d     = 1'b0;
      end else begin
        seen_d    = seen_nx;
        pos_d     = pos_nx;
        inv_d     = inv_nx;
        moved_d   = moved_nx;
        largest_d = largest_nx;
        bad_d     = bad_nx;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      seen_q      <= '0;
      pos_q       <= '0;
      inv_q       <= '0;
      moved_q     <= '0;
      largest_q   <= '0;
      bad_q       <= 1'b0;
    end else begin
      s0_valid_q  <= s0_valid_d;
      out_valid_q <= out_valid_d;
      seen_q      <= seen_d;
      pos_q       <= pos_d;
      inv_q       <= inv_d;
      moved_q     <= moved_d;
      largest_q   <= largest_d;
      bad_q       <= bad_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s0_word_q <= in_word_i;
    end
    if (fire && s0_word_q.last_entry) begin
      out_word_q.is_permutation  <= perm_ok;
      out_word_q.inversion_count <= perm_ok ? inv_nx : '0;
      out_word_q.group_size      <= pci_pkg::GrpW'(moved_nx);
      out_word_q.entry_count     <= pci_pkg::CntOutW'(pos_nx);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

>>> rtl/core/pci_checker.sv
// Port-level checks for the permutation checker, bound to the top level.
module pci_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input pci_pkg::in_word_t  in_word_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input pci_pkg::out_word_t out_word_o
);

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("result word changed while stalled");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_word_o.is_permutation |-> out_word_o.inversion_count == '0)
    else $error("inversion count nonzero on invalid permutation");

  a_group_le_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.is_permutation |->
      out_word_o.group_size <= out_word_o.entry_count && out_word_o.group_size != 1)
    else $error("group size inconsistent with entry count");

  a_inv_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.is_permutation |->
      (2 * 32'(out_word_o.inversion_count)) <=
      (32'(out_word_o.entry_count) * (32'(out_word_o.entry_count) - 1)))
    else $error("inversion count above n(n-1)/2");

  a_in_acc_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> !$isunknown(in_word_i.last_entry))
    else $error("accepted word has unknown last marker");

endmodule

bind permutation_check_and_inversions pci_checker u_pci_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_word_i   (in_word_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_o  (out_word_o)
);
